### rtl/smgp_pkg.sv
// Shared types, constants and the timestamp wrap extender for the metadata group parser.
package smgp_pkg;

    localparam int DEVICE_SLOTS   = 5;
    localparam int LEGACY_SAMPLES = 11;
    localparam int PACKED_SLOTS   = 5;
    localparam int HDR_SLOTS      = (DEVICE_SLOTS < PACKED_SLOTS) ? DEVICE_SLOTS : PACKED_SLOTS;
    localparam int SLOT_W         = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
    localparam int SEEK_W         = SLOT_W + 1;
    localparam int GROUPS_W       = 7;
    localparam int MAX_RESULTS    = 3;
    localparam int RES_IDX_W      = 2;
    localparam int TDATA_IN_W     = 128;
    localparam int TDATA_OUT_W    = 168;

    typedef enum logic [2:0] {
        KIND_EXP_START = 3'd0,
        KIND_EXP_END   = 3'd1,
        KIND_IMU       = 3'd2,
        KIND_OK        = 3'd3,
        KIND_ERR       = 3'd4
    } t_kind;

    // One wrap extender: raw 32-bit time plus a count of wraps.
    typedef struct packed {
        logic        seen;
        logic [31:0] prev;
        logic [31:0] wraps;
    } t_ext;

    typedef struct packed {
        logic [3:0]                        proto;
        logic [DEVICE_SLOTS-1:0][7:0]      types;
        logic [DEVICE_SLOTS-1:0][3:0]      counts;
        logic [31:0]                       start_raw;
        logic [31:0]                       end_raw;
    } t_header;

    // Words from the lowest: accel x, y, z, gyro x, y, z.
    typedef struct packed {
        logic [5:0][15:0] words;
        logic             valid;
    } t_sample;

    typedef struct packed {
        t_kind            kind;
        logic [63:0]      time_us;
        logic [3:0]       proto;
        logic [5:0][15:0] words;
        logic             valid;
        logic             last;
    } t_result;

    // Advance an extender by one raw reading; count a wrap on a backward jump
    // of more than half the range.
    function automatic t_ext widen(t_ext e, logic [31:0] raw);
        t_ext r;
        r = e;
        if (e.seen && (e.prev > raw) && ((e.prev - raw) > 32'h8000_0000)) begin
            r.wraps = e.wraps + 32'd1;
        end
        r.seen = 1'b1;
        r.prev = raw;
        return r;
    endfunction

endpackage

### rtl/smgp_unpack.sv
// Group unpacker: header fields in legacy or packed form and the IMU sample words.
module smgp_unpack
    import smgp_pkg::*;
(
    input  logic [63:0] i_group_high,
    input  logic [63:0] i_group_low,
    input  logic [7:0]  i_imu_type,
    output t_header     o_hdr,
    output t_sample     o_smp
);

    logic [5:0][15:0] w_words;
    logic             w_bad;

    always_comb begin
        o_hdr = '0;
        if (i_group_high == i_group_low) begin
            // legacy header: one IMU slot with a fixed sample count
            o_hdr.types[0]   = i_imu_type;
            o_hdr.counts[0]  = 4'(LEGACY_SAMPLES);
            o_hdr.start_raw  = i_group_high[63:32];
            o_hdr.end_raw    = i_group_high[31:0];
        end else begin
            o_hdr.proto = i_group_high[63:60];
            for (int i = 0; i < HDR_SLOTS; i++) begin
                o_hdr.types[i]  = i_group_high[52-12*i +: 8];
                o_hdr.counts[i] = i_group_high[48-12*i +: 4];
            end
            o_hdr.start_raw = i_group_low[63:32];
            o_hdr.end_raw   = i_group_low[31:0];
        end
    end

    assign w_words[0] = i_group_high[31:16];
    assign w_words[1] = i_group_high[15:0];
    assign w_words[2] = i_group_low[63:48];
    assign w_words[3] = i_group_low[47:32];
    assign w_words[4] = i_group_low[31:16];
    assign w_words[5] = i_group_low[15:0];

    assign w_bad = ((w_words[0] == 16'hFFFF) && (w_words[1] == 16'hFFFF)
                    && (w_words[2] == 16'hFFFF)) || (w_words[3] == 16'h8000);

    assign o_smp.words = w_bad ? '0 : w_words;
    assign o_smp.valid = !w_bad;

endmodule

### rtl/sensor_metadata_group_parser.sv
// Top level of the sensor metadata group parser: state, result buffer and stream ports.
//
// Takes a payload as 16-byte groups (tlast on the last group; tuser high means
// reset both timestamp extenders and drop the payload). The header group gives
// exposure start/end results with 64-bit extended times; each later group of
// the IMU slot type gives one IMU sample result; the last group adds a payload
// ok or payload error result, and only an ok payload commits the extender
// state. An accepted group waits in the input register and is decoded, once the
// result buffer is empty or its last result is leaving, into a three-entry
// result buffer that drains through the output port one result per cycle while
// the receiver is ready. A header group gives two results, or three if it also
// is the last group. The input register takes the next group while results
// still drain.
// The configuration register is taken at any time but is only to be written
// with no payload group in flight.
module sensor_metadata_group_parser
    import smgp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: IMU device type code
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [7:0]             i_cfg_data,
    // input groups
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [63:0] group_high, [127:64] group_low
    input  logic [TDATA_IN_W-1:0]  i_s_axis_tdata,
    // [0] op
    input  logic                   i_s_axis_tuser,
    input  logic                   i_s_axis_tlast,
    // results
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [63:0] time_us, [67:64] protocol, [83:68] accel_x, [99:84] accel_y,
    // [115:100] accel_z, [131:116] gyro_x, [147:132] gyro_y, [163:148] gyro_z,
    // [164] sample_valid, [167:165] zero
    output logic [TDATA_OUT_W-1:0] o_m_axis_tdata,
    // [2:0] kind
    output logic [2:0]             o_m_axis_tuser,
    output logic                   o_m_axis_tlast
);

    typedef struct packed {
        logic [SLOT_W-1:0] ptr;
        logic [3:0]        left;
    } t_seek;

    // First slot at or after p with a nonzero count; slot 0, empty if none.
    function automatic t_seek seek(logic [DEVICE_SLOTS-1:0][3:0] counts, logic [SEEK_W-1:0] p);
        t_seek r;
        logic  found;
        r     = '0;
        found = 1'b0;
        for (int i = 0; i < DEVICE_SLOTS; i++) begin
            if (!found && (SEEK_W'(i) >= p) && (counts[i] != 4'd0)) begin
                found  = 1'b1;
                r.ptr  = SLOT_W'(i);
                r.left = counts[i];
            end
        end
        return r;
    endfunction

    // configuration
    logic [7:0] r_imu_type;

    // input register
    logic                   r_in_valid;
    logic                   r_in_op;
    logic [63:0]            r_in_hi;
    logic [63:0]            r_in_lo;
    logic                   r_in_fin;

    // parser state; extenders: _c committed, _w working
    t_ext                          r_exp_c, r_exp_w, r_imu_c, r_imu_w;
    logic                          r_in_payload;
    logic                          r_bad;
    logic [GROUPS_W-1:0]           r_groups;
    logic [SLOT_W-1:0]             r_ptr;
    logic [3:0]                    r_left;
    logic [DEVICE_SLOTS-1:0][7:0]  r_types;
    logic [DEVICE_SLOTS-1:0][3:0]  r_counts;

    t_ext                          n_exp_c, n_exp_w, n_imu_c, n_imu_w;
    logic                          n_in_payload;
    logic                          n_bad;
    logic [GROUPS_W-1:0]           n_groups;
    logic [SLOT_W-1:0]             n_ptr;
    logic [3:0]                    n_left;
    logic [DEVICE_SLOTS-1:0][7:0]  n_types;
    logic [DEVICE_SLOTS-1:0][3:0]  n_counts;

    // result buffer, entry 0 on the output port
    t_result                r_buf [MAX_RESULTS];
    logic [RES_IDX_W-1:0]   r_bcnt;
    t_result                w_res [MAX_RESULTS];
    logic [RES_IDX_W-1:0]   w_nres;

    t_header w_hdr;
    t_sample w_smp;
    logic    w_buf_free;
    logic    w_process;
    logic    w_in_xfer;
    logic    w_out_xfer;

    smgp_unpack u_unpack (
        .i_group_high (r_in_hi),
        .i_group_low  (r_in_lo),
        .i_imu_type   (r_imu_type),
        .o_hdr        (w_hdr),
        .o_smp        (w_smp)
    );

    assign o_cfg_ready     = 1'b1;
    assign w_out_xfer      = o_m_axis_tvalid && i_m_axis_tready;
    assign w_buf_free      = (r_bcnt == '0) || ((r_bcnt == RES_IDX_W'(1)) && i_m_axis_tready);
    assign w_process       = r_in_valid && w_buf_free;
    assign o_s_axis_tready = !r_in_valid || w_process;
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;

    // Decode the registered group against the current state.
    always_comb begin
        t_ext                 e1;
        t_seek                sk;
        logic [GROUPS_W-1:0]  total;
        logic [3:0]           left_dec;
        logic [7:0]           cur_type;
        logic                 ok;

        n_exp_c      = r_exp_c;
        n_exp_w      = r_exp_w;
        n_imu_c      = r_imu_c;
        n_imu_w      = r_imu_w;
        n_in_payload = r_in_payload;
        n_bad        = r_bad;
        n_groups     = r_groups;
        n_ptr        = r_ptr;
        n_left       = r_left;
        n_types      = r_types;
        n_counts     = r_counts;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            w_res[i] = '0;
        end
        w_nres   = '0;
        e1       = '0;
        sk       = '0;
        total    = '0;
        left_dec = '0;
        cur_type = r_types[r_ptr];
        ok       = 1'b0;

        if (r_in_op) begin
            // clear both extenders, abandon the payload quietly
            n_exp_c      = '0;
            n_exp_w      = '0;
            n_imu_c      = '0;
            n_imu_w      = '0;
            n_in_payload = 1'b0;
            n_bad        = 1'b0;
            n_groups     = '0;
            n_ptr        = '0;
            n_left       = '0;
        end else begin
            if (!r_in_payload) begin
                // header group
                n_types  = w_hdr.types;
                n_counts = w_hdr.counts;
                for (int i = 0; i < DEVICE_SLOTS; i++) begin
                    total = total + GROUPS_W'(w_hdr.counts[i]);
                end
                n_groups     = total;
                sk           = seek(w_hdr.counts, '0);
                n_ptr        = sk.ptr;
                n_left       = sk.left;
                n_in_payload = 1'b1;
                n_bad        = 1'b0;
                e1           = widen(r_exp_w, w_hdr.start_raw);
                n_exp_w      = widen(e1, w_hdr.end_raw);
                w_res[0].kind    = KIND_EXP_START;
                w_res[0].time_us = {e1.wraps, w_hdr.start_raw};
                w_res[0].proto   = w_hdr.proto;
                w_res[1].kind    = KIND_EXP_END;
                w_res[1].time_us = {n_exp_w.wraps, w_hdr.end_raw};
                w_res[1].proto   = w_hdr.proto;
                w_nres           = RES_IDX_W'(2);
            end else if (r_bad || (r_groups == '0)) begin
                // surplus group, or anything after one: mark and drop
                n_bad = 1'b1;
            end else begin
                n_groups = r_groups - GROUPS_W'(1);
                left_dec = (r_left != 4'd0) ? (r_left - 4'd1) : 4'd0;
                n_left   = left_dec;
                if (left_dec == 4'd0) begin
                    sk     = seek(r_counts, SEEK_W'(r_ptr) + SEEK_W'(1));
                    n_ptr  = sk.ptr;
                    n_left = sk.left;
                end
                if (cur_type == r_imu_type) begin
                    n_imu_w          = widen(r_imu_w, r_in_hi[63:32]);
                    w_res[0].kind    = KIND_IMU;
                    w_res[0].time_us = {n_imu_w.wraps, r_in_hi[63:32]};
                    w_res[0].words   = w_smp.words;
                    w_res[0].valid   = w_smp.valid;
                    w_nres           = RES_IDX_W'(1);
                end
            end

            if (r_in_fin) begin
                ok = !n_bad && (n_groups == '0);
                if (ok) begin
                    n_exp_c = n_exp_w;
                    n_imu_c = n_imu_w;
                end else begin
                    n_exp_w = r_exp_c;
                    n_imu_w = r_imu_c;
                end
                n_in_payload       = 1'b0;
                n_bad              = 1'b0;
                n_groups           = '0;
                n_ptr              = '0;
                n_left             = '0;
                w_res[w_nres].kind = ok ? KIND_OK : KIND_ERR;
                w_nres             = w_nres + RES_IDX_W'(1);
            end
        end

        // flag the last result of this group
        for (int i = 0; i < MAX_RESULTS; i++) begin
            w_res[i].last = (w_nres != '0) && (RES_IDX_W'(i) == (w_nres - RES_IDX_W'(1)));
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imu_type   <= '0;
            r_in_valid   <= 1'b0;
            r_exp_c      <= '0;
            r_exp_w      <= '0;
            r_imu_c      <= '0;
            r_imu_w      <= '0;
            r_in_payload <= 1'b0;
            r_bad        <= 1'b0;
            r_groups     <= '0;
            r_ptr        <= '0;
            r_left       <= '0;
            r_types      <= '0;
            r_counts     <= '0;
            r_bcnt       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_imu_type <= i_cfg_data;
            end
            if (w_in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (w_process) begin
                r_in_valid <= 1'b0;
            end
            if (w_process) begin
                r_exp_c      <= n_exp_c;
                r_exp_w      <= n_exp_w;
                r_imu_c      <= n_imu_c;
                r_imu_w      <= n_imu_w;
                r_in_payload <= n_in_payload;
                r_bad        <= n_bad;
                r_groups     <= n_groups;
                r_ptr        <= n_ptr;
                r_left       <= n_left;
                r_types      <= n_types;
                r_counts     <= n_counts;
                r_bcnt       <= w_nres;
            end else if (w_out_xfer) begin
                r_bcnt <= r_bcnt - RES_IDX_W'(1);
            end
        end
    end

    // payload registers: input group and result buffer
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_op  <= i_s_axis_tuser;
            r_in_hi  <= i_s_axis_tdata[63:0];
            r_in_lo  <= i_s_axis_tdata[127:64];
            r_in_fin <= i_s_axis_tlast;
        end
        if (w_process) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                r_buf[i] <= w_res[i];
            end
        end else if (w_out_xfer) begin
            // advance the buffer by one entry
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

    assign o_m_axis_tvalid = (r_bcnt != '0);
    assign o_m_axis_tuser  = r_buf[0].kind;
    assign o_m_axis_tlast  = r_buf[0].last;
    assign o_m_axis_tdata  = {3'b000, r_buf[0].valid, r_buf[0].words,
                              r_buf[0].proto, r_buf[0].time_us};

endmodule
